// File: src/sacc_pkg.sv
// shared constants and types of the set-associative cache tag controller
package sacc_pkg;

    localparam int ADDR_W      = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic ACTION_WRITE = 1'b1;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctl;

endpackage

// File: src/sacc_front.sv
// front end: accepts transactions, splits the address and queues the requests
module sacc_front #(
    parameter int TAG_W = 17,
    parameter int SET_W = 10,
    parameter int OFF_W = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_action,
    input  logic [sacc_pkg::ADDR_W-1:0] i_address,
    input  sacc_pkg::t_back_ctl         i_back_ctl,
    output logic                        o_q_valid,
    output logic                        o_q_write,
    output logic [TAG_W-1:0]            o_q_tag,
    output logic [SET_W-1:0]            o_q_set
);
    import sacc_pkg::*;

    logic              r_q_write [QUEUE_DEPTH];
    logic [TAG_W-1:0]  r_q_tag   [QUEUE_DEPTH];
    logic [SET_W-1:0]  r_q_set   [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic w_push;
    logic w_pop;
    logic w_is_write;

    assign o_stall    = (r_count == QCNT_W'(QUEUE_DEPTH)) || i_back_ctl.clearing;
    assign w_push     = i_valid && !o_stall;
    assign w_pop      = i_back_ctl.pop;
    assign w_is_write = (i_action == ACTION_WRITE);

    assign o_q_valid = (r_count != '0);
    assign o_q_write = r_q_write[r_rd_ptr];
    assign o_q_tag   = r_q_tag[r_rd_ptr];
    assign o_q_set   = r_q_set[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({w_push, w_pop})
                2'b10: r_count <= r_count + 1'b1;
                2'b01: r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_write[r_wr_ptr] <= w_is_write;
            r_q_tag[r_wr_ptr]   <= i_address[OFF_W+SET_W +: TAG_W];
            r_q_set[r_wr_ptr]   <= i_address[OFF_W +: SET_W];
        end
    end

endmodule

// File: src/sacc_back.sv
// back end: set lookup, lru update, tag and state memories, result register
module sacc_back #(
    parameter int NUM_SETS = 1024,
    parameter int NUM_WAYS = 4,
    parameter int TAG_W    = 17
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  logic                         i_q_write,
    input  logic [TAG_W-1:0]             i_q_tag,
    input  logic [$clog2(NUM_SETS)-1:0]  i_q_set,
    output sacc_pkg::t_back_ctl          o_back_ctl,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_hit,
    output logic                         o_wrote_back,
    output logic                         o_replaced,
    output logic [$clog2(NUM_WAYS)-1:0]  o_way
);
    import sacc_pkg::*;

    localparam int SET_W = $clog2(NUM_SETS);
    localparam int WAY_W = $clog2(NUM_WAYS);
    localparam int AGE_W = WAY_W;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK} t_state;

    typedef struct packed {
        logic [NUM_WAYS-1:0]            valid;
        logic [NUM_WAYS-1:0]            dirty;
        logic [NUM_WAYS-1:0][AGE_W-1:0] age;
    } t_set_state;

    typedef logic [NUM_WAYS-1:0][TAG_W-1:0] t_tag_row;

    t_tag_row   r_tag_mem [NUM_SETS];
    t_set_state r_st_mem  [NUM_SETS];

    t_state           r_state;
    logic [SET_W-1:0] r_clr_set;
    logic             r_out_valid;
    logic             r_out_hit;
    logic             r_out_wrote_back;
    logic             r_out_replaced;
    logic [WAY_W-1:0] r_out_way;

    t_tag_row         r_tag_rd;
    t_set_state       r_st_rd;
    logic             r_req_write;
    logic [TAG_W-1:0] r_req_tag;
    logic [SET_W-1:0] r_req_set;

    logic                w_start;
    logic [NUM_WAYS-1:0] w_hit_vec;
    logic                w_hit;
    logic                w_empty;
    logic [WAY_W-1:0]    w_hit_way;
    logic [WAY_W-1:0]    w_empty_way;
    logic [WAY_W-1:0]    w_victim;
    logic [AGE_W-1:0]    w_best_age;
    logic [WAY_W-1:0]    n_sel;
    logic [AGE_W-1:0]    w_sel_age;
    logic                w_fill_empty;
    t_set_state          n_set_state;
    t_tag_row            n_tag_row;
    logic                n_wrote_back;
    logic                n_replaced;

    assign w_start = (r_state == S_IDLE) && i_q_valid && (!r_out_valid || !i_stall);

    assign o_back_ctl.pop      = w_start;
    assign o_back_ctl.clearing = (r_state == S_CLEAR);

    assign o_valid      = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_wrote_back = r_out_wrote_back;
    assign o_replaced   = r_out_replaced;
    assign o_way        = r_out_way;

    always_comb begin
        w_hit_way   = '0;
        w_empty_way = '0;
        w_hit       = 1'b0;
        w_empty     = 1'b0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            w_hit_vec[w] = r_st_rd.valid[w] && (r_tag_rd[w] == r_req_tag);
            if (w_hit_vec[w]) begin
                w_hit     = 1'b1;
                w_hit_way = WAY_W'(w);
            end
            if (!r_st_rd.valid[w]) begin
                w_empty     = 1'b1;
                w_empty_way = WAY_W'(w);
            end
        end
    end

    // oldest way, lowest index on a tie
    always_comb begin
        w_best_age = '0;
        w_victim   = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (r_st_rd.age[w] > w_best_age) begin
                w_best_age = r_st_rd.age[w];
                w_victim   = WAY_W'(w);
            end
        end
    end

    always_comb begin
        priority if (w_hit) begin
            n_sel = w_hit_way;
        end else if (w_empty) begin
            n_sel = w_empty_way;
        end else begin
            n_sel = w_victim;
        end
        w_sel_age    = r_st_rd.age[n_sel];
        w_fill_empty = !w_hit && w_empty;
        n_replaced   = !w_hit && !w_empty;
        n_wrote_back = n_replaced && r_st_rd.dirty[n_sel];

        n_set_state = r_st_rd;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (WAY_W'(w) == n_sel) begin
                n_set_state.age[w] = '0;
            end else if (r_st_rd.valid[w] && (w_fill_empty || (r_st_rd.age[w] < w_sel_age))) begin
                n_set_state.age[w] = r_st_rd.age[w] + 1'b1;
            end
        end
        n_set_state.valid[n_sel] = 1'b1;
        n_set_state.dirty[n_sel] = r_req_write || (w_hit && r_st_rd.dirty[n_sel]);

        n_tag_row = r_tag_rd;
        if (!w_hit) begin
            n_tag_row[n_sel] = r_req_tag;
        end
    end

    // tag and state memories
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_tag_rd    <= r_tag_mem[i_q_set];
            r_st_rd     <= r_st_mem[i_q_set];
            r_req_write <= i_q_write;
            r_req_tag   <= i_q_tag;
            r_req_set   <= i_q_set;
        end
        if (r_state == S_LOOK) begin
            r_tag_mem[r_req_set] <= n_tag_row;
        end
        if (r_state == S_CLEAR) begin
            r_st_mem[r_clr_set] <= '0;
        end else if (r_state == S_LOOK) begin
            r_st_mem[r_req_set] <= n_set_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_set   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_set <= r_clr_set + 1'b1;
                    if (r_clr_set == SET_W'(NUM_SETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_start) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_out_valid      <= 1'b1;
                    r_out_hit        <= w_hit;
                    r_out_wrote_back <= n_wrote_back;
                    r_out_replaced   <= n_replaced;
                    r_out_way        <= n_sel;
                    r_state          <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: src/set_assoc_cache_tag_controller_unit.sv
// top level of the set-associative write-back cache tag controller
// usage:
//   input channel (i_valid / o_stall) carries one access per transaction:
//   i_action (0 read, 1 write) and the 32-bit byte address i_address
//   output channel (o_valid / i_stall) returns one result transaction per
//   access, in order: o_hit, o_wrote_back, o_replaced and the way o_way
//   accepted accesses go into a two-entry queue; the back end reads the set
//   state into the lookup registers and writes the updated tags, valid,
//   dirty and lru ages in the next cycle, when the result is registered, so
//   the lookup registers and the result register lie between an access
//   leaving the queue and its result; the back end starts no new access
//   until this read-modify-write is done, nor while a stalled result waits
//   after reset the set state memory is cleared one set per cycle, with
//   o_stall high; the block then starts with all lines invalid
//   a stalled result holds in the output register; the queue keeps accepting
//   until it holds two transactions, then o_stall rises
module set_assoc_cache_tag_controller_unit #(
    parameter int NUM_SETS   = 1024,
    parameter int NUM_WAYS   = 4,
    parameter int LINE_BYTES = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_action,
    input  logic [sacc_pkg::ADDR_W-1:0]  i_address,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_hit,
    output logic                         o_wrote_back,
    output logic                         o_replaced,
    output logic [$clog2(NUM_WAYS)-1:0]  o_way
);
    import sacc_pkg::*;

    localparam int SET_W = $clog2(NUM_SETS);
    localparam int OFF_W = $clog2(LINE_BYTES);
    localparam int TAG_W = ADDR_W - OFF_W - SET_W;

    t_back_ctl        w_back_ctl;
    logic             w_q_valid;
    logic             w_q_write;
    logic [TAG_W-1:0] w_q_tag;
    logic [SET_W-1:0] w_q_set;

    sacc_front #(
        .TAG_W (TAG_W),
        .SET_W (SET_W),
        .OFF_W (OFF_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_action   (i_action),
        .i_address  (i_address),
        .i_back_ctl (w_back_ctl),
        .o_q_valid  (w_q_valid),
        .o_q_write  (w_q_write),
        .o_q_tag    (w_q_tag),
        .o_q_set    (w_q_set)
    );

    sacc_back #(
        .NUM_SETS (NUM_SETS),
        .NUM_WAYS (NUM_WAYS),
        .TAG_W    (TAG_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_write    (w_q_write),
        .i_q_tag      (w_q_tag),
        .i_q_set      (w_q_set),
        .o_back_ctl   (w_back_ctl),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hit        (o_hit),
        .o_wrote_back (o_wrote_back),
        .o_replaced   (o_replaced),
        .o_way        (o_way)
    );

    a_pop_needs_entry: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_back_ctl.pop |-> w_q_valid
    ) else $error("queue popped while empty");

    a_result_follows_pop: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_back_ctl.pop, 2)
    ) else $error("result without a dequeued transaction");

    a_clear_after_reset: assert property (
        @(posedge i_clk)
        !i_rst_n |=> o_stall
    ) else $error("input not stalled while clearing after reset");

endmodule

// File: dv/set_assoc_cache_tag_controller_unit_test.sv
// self-checking testbench of the set-associative cache tag controller
`timescale 1ns / 100ps

module set_assoc_cache_tag_controller_unit_test;

    localparam int NUM_SETS   = 1024;
    localparam int NUM_WAYS   = 4;
    localparam int LINE_BYTES = 32;
    localparam int ADDR_W     = sacc_pkg::ADDR_W;
    localparam int OFFSET_W   = $clog2(LINE_BYTES);
    localparam int SET_W      = $clog2(NUM_SETS);
    localparam int TAG_W      = ADDR_W - SET_W - OFFSET_W;
    localparam int WAY_W      = $clog2(NUM_WAYS);
    localparam int LINE_COUNT = NUM_SETS * NUM_WAYS;
    localparam int unsigned TAG_MAX = (1 << TAG_W) - 1;

    localparam logic ACTION_WRITE = sacc_pkg::ACTION_WRITE;
    localparam logic ACTION_READ  = ~sacc_pkg::ACTION_WRITE;

    localparam int RANDOM_ACCESSES = 850;
    localparam int PRESSURE_AT     = 300;
    localparam int PRESSURE_CYCLES = 150;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int DRAIN_CYCLES    = 10;

    typedef struct packed {
        logic             hit;
        logic             wrote_back;
        logic             replaced;
        logic [WAY_W-1:0] way;
    } t_lookup_result;

    class t_tag_scoreboard;
        logic [TAG_W-1:0] tag_bits [LINE_COUNT];
        bit               valid_bits [LINE_COUNT];
        bit               dirty_bits [LINE_COUNT];
        int unsigned      age_bits [LINE_COUNT];
        t_lookup_result   expected_lookups [$];
        int               errors;
        int               accesses, writes, hits, fills, evictions, writebacks;

        function new();
            for (int i = 0; i < LINE_COUNT; i++) begin
                tag_bits[i]   = '0;
                valid_bits[i] = 1'b0;
                dirty_bits[i] = 1'b0;
                age_bits[i]   = 0;
            end
            errors     = 0;
            accesses   = 0;
            writes     = 0;
            hits       = 0;
            fills      = 0;
            evictions  = 0;
            writebacks = 0;
        endfunction

        function int pending();
            return expected_lookups.size();
        endfunction

        // age valid ways younger than limit, accessed way becomes most recent
        function void refresh_ages(int unsigned base, int unsigned pick, int unsigned limit);
            for (int unsigned w = 0; w < NUM_WAYS; w++) begin
                if (w != pick && valid_bits[base + w] && age_bits[base + w] < limit)
                    age_bits[base + w] = (age_bits[base + w] + 1) % (1 << WAY_W);
            end
            age_bits[base + pick] = 0;
        endfunction

        function void note_access(logic act, logic [ADDR_W-1:0] addr);
            int unsigned    line_no, set_no, base, way_no, best;
            logic [TAG_W-1:0] tag;
            bit             found, has_free;
            t_lookup_result res;
            line_no  = addr >> OFFSET_W;
            set_no   = line_no % NUM_SETS;
            tag      = TAG_W'(line_no / NUM_SETS);
            base     = set_no * NUM_WAYS;
            res      = '0;
            found    = 1'b0;
            has_free = 1'b0;
            way_no   = 0;
            accesses++;
            for (int unsigned w = 0; w < NUM_WAYS; w++) begin
                if (!found && valid_bits[base + w] && tag_bits[base + w] == tag) begin
                    found  = 1'b1;
                    way_no = w;
                end
            end
            if (found) begin
                res.hit = 1'b1;
                hits++;
                refresh_ages(base, way_no, age_bits[base + way_no]);
            end else begin
                for (int unsigned w = 0; w < NUM_WAYS; w++) begin
                    if (!has_free && !valid_bits[base + w]) begin
                        has_free = 1'b1;
                        way_no   = w;
                    end
                end
                if (has_free) begin
                    fills++;
                    refresh_ages(base, way_no, NUM_WAYS);
                end else begin
                    best = 0;
                    way_no = 0;
                    for (int unsigned w = 0; w < NUM_WAYS; w++) begin
                        if (age_bits[base + w] > best) begin
                            best   = age_bits[base + w];
                            way_no = w;
                        end
                    end
                    res.replaced   = 1'b1;
                    res.wrote_back = dirty_bits[base + way_no];
                    evictions++;
                    if (res.wrote_back)
                        writebacks++;
                    refresh_ages(base, way_no, age_bits[base + way_no]);
                end
                valid_bits[base + way_no] = 1'b1;
                dirty_bits[base + way_no] = 1'b0;
                tag_bits[base + way_no]   = tag;
            end
            if (act == ACTION_WRITE) begin
                dirty_bits[base + way_no] = 1'b1;
                writes++;
            end
            res.way = WAY_W'(way_no);
            expected_lookups.push_back(res);
        endfunction

        function void compare_field(string name, logic [WAY_W-1:0] want, logic [WAY_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic hit, logic wrote_back, logic replaced,
                                   logic [WAY_W-1:0] way);
            t_lookup_result want;
            if (expected_lookups.size() == 0) begin
                errors++;
                $display("%0t: result expected none, got hit %0d wb %0d repl %0d way %0d",
                         $time, hit, wrote_back, replaced, way);
                return;
            end
            want = expected_lookups.pop_front();
            compare_field("hit", WAY_W'(want.hit), WAY_W'(hit));
            compare_field("wrote_back", WAY_W'(want.wrote_back), WAY_W'(wrote_back));
            compare_field("replaced", WAY_W'(want.replaced), WAY_W'(replaced));
            compare_field("way", want.way, way);
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n   = 1'b0;
    logic              i_valid   = 1'b0;
    logic              i_action  = 1'b0;
    logic [ADDR_W-1:0] i_address = '0;
    logic              i_stall   = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic              o_hit;
    logic              o_wrote_back;
    logic              o_replaced;
    logic [WAY_W-1:0]  o_way;

    t_tag_scoreboard board;
    int              accesses_sent = 0;

    set_assoc_cache_tag_controller_unit #(
        .NUM_SETS   (NUM_SETS),
        .NUM_WAYS   (NUM_WAYS),
        .LINE_BYTES (LINE_BYTES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_address    (i_address),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hit        (o_hit),
        .o_wrote_back (o_wrote_back),
        .o_replaced   (o_replaced),
        .o_way        (o_way)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // inputs are noted before results are checked so both orders stay fixed
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            board.note_access(i_action, i_address);
        if (i_rst_n && o_valid && !i_stall)
            board.check_result(o_hit, o_wrote_back, o_replaced, o_way);
    end

    function automatic logic [ADDR_W-1:0] make_addr(int unsigned tag,
                                                    int unsigned set_no,
                                                    int unsigned offset);
        return {TAG_W'(tag), SET_W'(set_no), OFFSET_W'(offset)};
    endfunction

    task automatic send_access(logic act, logic [ADDR_W-1:0] addr);
        int gap;
        gap = (accesses_sent % 128 < 32) ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_action  <= act;
        i_address <= addr;
        do @(posedge i_clk); while (o_stall);
        accesses_sent++;
    endtask

    task automatic send_random_access(const ref logic [SET_W-1:0] set_pool [8],
                                      const ref logic [TAG_W-1:0] tag_pool [6]);
        logic              act;
        logic [ADDR_W-1:0] addr;
        act = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 85)
            addr = make_addr(int'(tag_pool[$urandom_range(0, 5)]),
                             int'(set_pool[$urandom_range(0, 7)]), $urandom);
        else
            addr = $urandom;
        send_access(act, addr);
    endtask

    // result side stalls at random, with one long hold-off to back up the queue
    initial begin
        int hold;
        int taken;
        taken = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (taken == PRESSURE_AT)
                hold = PRESSURE_CYCLES;
            else if (taken % 128 >= 64 && taken % 128 < 96)
                hold = 0;
            else
                hold = $urandom_range(0, 3);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
            taken++;
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("set_assoc_cache_tag_controller_unit: mismatch");
        $finish;
    end

    initial begin
        logic [SET_W-1:0] set_pool [8];
        logic [TAG_W-1:0] tag_pool [6];
        board = new();
        set_pool = '{SET_W'(0), SET_W'(1), SET_W'(2), SET_W'(511), SET_W'(512),
                     SET_W'(NUM_SETS - 1), SET_W'($urandom), SET_W'($urandom)};
        tag_pool = '{TAG_W'(0), TAG_W'(1), {TAG_W{1'b1}}, TAG_W'(1 << (TAG_W - 1)),
                     TAG_W'($urandom), TAG_W'($urandom)};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill set 0, hit, then evict a dirty and a clean line
        send_access(ACTION_READ, '0);
        send_access(ACTION_WRITE, {ADDR_W{1'b1}});
        send_access(ACTION_WRITE, make_addr(0, 0, (1 << OFFSET_W) - 1));
        send_access(ACTION_READ, make_addr(1, 0, 4));
        send_access(ACTION_READ, make_addr(2, 0, 8));
        send_access(ACTION_READ, make_addr(3, 0, 16));
        send_access(ACTION_READ, make_addr(2, 0, 0));
        send_access(ACTION_READ, make_addr(4, 0, 0));
        send_access(ACTION_READ, make_addr(5, 0, 0));
        send_access(ACTION_WRITE, make_addr(5, 0, 1));
        send_access(ACTION_READ, make_addr(6, 0, 0));
        send_access(ACTION_WRITE, make_addr(7, 0, 0));
        // top set: all dirty, hit the oldest, then evictions with write-back
        send_access(ACTION_WRITE, make_addr(1, NUM_SETS - 1, 0));
        send_access(ACTION_WRITE, make_addr(2, NUM_SETS - 1, 0));
        send_access(ACTION_WRITE, make_addr(3, NUM_SETS - 1, 0));
        send_access(ACTION_READ, make_addr(TAG_MAX, NUM_SETS - 1, 3));
        send_access(ACTION_READ, make_addr(8, NUM_SETS - 1, 0));
        send_access(ACTION_READ, make_addr(9, NUM_SETS - 1, 0));
        send_access(ACTION_READ, make_addr(TAG_MAX, NUM_SETS - 1, 0));
        send_access(ACTION_WRITE, make_addr(10, NUM_SETS - 1, 0));

        for (int i = 0; i < RANDOM_ACCESSES; i++)
            send_random_access(set_pool, tag_pool);
        i_valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d accesses (%0d writes): %0d hits, %0d fills of free ways",
                 board.accesses, board.writes, board.hits, board.fills);
        $display("%0d evictions, %0d of them with write-back",
                 board.evictions, board.writebacks);
        if (board.errors == 0)
            $display("set_assoc_cache_tag_controller_unit: match");
        else
            $display("set_assoc_cache_tag_controller_unit: mismatch");
        $finish;
    end

endmodule
